@@ rtl/sfrt_pkg.sv @@
`default_nettype none

package sfrt_pkg;

  localparam int NumNeuronsDef = 128;
  localparam int FanoutDef     = 16;

  // Offset carried by source and target codes on an add request
  localparam logic [7:0] CodeOffset = 8'd100;

  localparam logic ReqAdd   = 1'b0;
  localparam logic ReqSpike = 1'b1;

  localparam logic KindAck = 1'b0;
  localparam logic KindFwd = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CNT,
    ST_ADD,
    ST_SP_RD,
    ST_SP_OUT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/sfrt_req_if.sv @@
`default_nettype none

interface sfrt_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] source_neuron;
  logic [7:0] target_code;
  logic [7:0] target_synapse_in;

  modport source (
    output valid, req_type, source_neuron, target_code, target_synapse_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, source_neuron, target_code, target_synapse_in,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/sfrt_res_if.sv @@
`default_nettype none

interface sfrt_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       accepted;
  logic [7:0] source_index;
  logic [7:0] target_neuron;
  logic [7:0] target_synapse;
  logic       last;

  modport source (
    output valid, result_kind, accepted, source_index, target_neuron, target_synapse,
           last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, accepted, source_index, target_neuron, target_synapse,
           last,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/sfrt_ram.sv @@
`default_nettype none

module sfrt_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/spike_fanout_routing_table_core.sv @@
// Channel  Dir  Payload
// req_i    in   req_type, source_neuron, target_code, target_synapse_in
// res_o    out  result_kind, accepted, source_index, target_neuron, target_synapse, last
//
// One item at a time. An add passes through ST_RD_CNT and ST_ADD before its acknowledgement
// is loaded; a spike does the count lookup in ST_RD_CNT, then steps through ST_SP_RD and
// ST_SP_OUT per stored address, since the single entry memory port is read once per address.
// Reset clears the per-source count valid bits at once; no clearing pass is needed.
// A stalled result holds the output register and the sequencer waits behind it.
`default_nettype none

module spike_fanout_routing_table_core #(
  parameter int NUM_NEURONS = sfrt_pkg::NumNeuronsDef,
  parameter int FANOUT      = sfrt_pkg::FanoutDef
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  sfrt_req_if.sink   req_i,
  sfrt_res_if.source res_o
);

  localparam int IW = $clog2(NUM_NEURONS);
  localparam int CW = $clog2(FANOUT + 1);
  localparam int EW = $clog2(NUM_NEURONS * FANOUT);

  sfrt_pkg::state_e state_q, state_d;

  logic          kind_q, kind_d;
  logic [7:0]    idx_q, idx_d;
  logic [7:0]    tgt_q, tgt_d;
  logic [7:0]    syn_q, syn_d;
  logic          rng_q, rng_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] slot_q, slot_d;

  logic          out_vld_q, out_vld_d;
  logic          out_kind_q, out_kind_d;
  logic          out_acc_q, out_acc_d;
  logic [7:0]    out_src_q, out_src_d;
  logic [7:0]    out_tgt_q, out_tgt_d;
  logic [7:0]    out_syn_q, out_syn_d;
  logic          out_last_q, out_last_d;

  logic [NUM_NEURONS-1:0] cnt_vld_q, cnt_vld_d;

  logic          in_fire;
  logic          out_free;
  logic [7:0]    in_idx;
  logic [IW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_rdata;
  logic [CW-1:0] cnt_look;
  logic          cnt_we;
  logic [CW-1:0] slot_sel;
  logic [EW-1:0] ent_addr;
  logic          ent_we;
  logic [15:0]   ent_rdata;
  logic          add_ok;

  assign req_i.ready = (state_q == sfrt_pkg::ST_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || res_o.ready;

  assign in_idx = (req_i.req_type == sfrt_pkg::ReqAdd)
                ? req_i.source_neuron - sfrt_pkg::CodeOffset
                : req_i.source_neuron;

  // Look the count up in the accept cycle so that it is ready in ST_RD_CNT
  assign cnt_raddr = (state_q == sfrt_pkg::ST_IDLE) ? in_idx[IW-1:0] : idx_q[IW-1:0];
  assign cnt_look  = cnt_vld_q[idx_q[IW-1:0]] ? cnt_rdata : '0;

  assign add_ok   = rng_q && (cnt_q < CW'(FANOUT));
  assign slot_sel = (state_q == sfrt_pkg::ST_ADD) ? cnt_q : slot_q;
  assign ent_addr = EW'(idx_q[IW-1:0]) * EW'(FANOUT) + EW'(slot_sel);

  assign cnt_we = (state_q == sfrt_pkg::ST_ADD) && out_free && add_ok;
  assign ent_we = cnt_we;

  sfrt_ram #(
    .Width (CW),
    .Depth (NUM_NEURONS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (idx_q[IW-1:0]),
    .wdata_i (cnt_q + CW'(1)),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  sfrt_ram #(
    .Width (16),
    .Depth (NUM_NEURONS * FANOUT)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_addr),
    .wdata_i ({tgt_q, syn_q}),
    .raddr_i (ent_addr),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    idx_d      = idx_q;
    tgt_d      = tgt_q;
    syn_d      = syn_q;
    rng_d      = rng_q;
    cnt_d      = cnt_q;
    slot_d     = slot_q;
    cnt_vld_d  = cnt_vld_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    out_kind_d = out_kind_q;
    out_acc_d  = out_acc_q;
    out_src_d  = out_src_q;
    out_tgt_d  = out_tgt_q;
    out_syn_d  = out_syn_q;
    out_last_d = out_last_q;

    unique case (state_q)
      sfrt_pkg::ST_IDLE: begin
        if (in_fire) begin
          kind_d  = req_i.req_type;
          idx_d   = in_idx;
          tgt_d   = req_i.target_code - sfrt_pkg::CodeOffset;
          syn_d   = req_i.target_synapse_in;
          state_d = sfrt_pkg::ST_RD_CNT;
        end
      end
      sfrt_pkg::ST_RD_CNT: begin
        cnt_d  = cnt_look;
        rng_d  = ({1'b0, idx_q} < 9'(NUM_NEURONS));
        slot_d = '0;
        if (kind_q == sfrt_pkg::ReqAdd) begin
          state_d = sfrt_pkg::ST_ADD;
        end else if (({1'b0, idx_q} >= 9'(NUM_NEURONS)) || (cnt_look == '0)) begin
          // drop: nothing to forward
          state_d = sfrt_pkg::ST_IDLE;
        end else begin
          state_d = sfrt_pkg::ST_SP_RD;
        end
      end
      sfrt_pkg::ST_ADD: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = sfrt_pkg::KindAck;
          out_acc_d  = add_ok;
          out_src_d  = idx_q;
          out_tgt_d  = tgt_q;
          out_syn_d  = syn_q;
          out_last_d = 1'b1;
          if (add_ok) begin
            cnt_vld_d[idx_q[IW-1:0]] = 1'b1;
          end
          state_d = sfrt_pkg::ST_IDLE;
        end
      end
      sfrt_pkg::ST_SP_RD: begin
        state_d = sfrt_pkg::ST_SP_OUT;
      end
      sfrt_pkg::ST_SP_OUT: begin
        // read address holds on slot_q, so the entry stays put while stalled
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = sfrt_pkg::KindFwd;
          out_acc_d  = 1'b0;
          out_src_d  = idx_q;
          out_tgt_d  = ent_rdata[15:8];
          out_syn_d  = ent_rdata[7:0];
          out_last_d = (slot_q + CW'(1)) == cnt_q;
          if ((slot_q + CW'(1)) == cnt_q) begin
            state_d = sfrt_pkg::ST_IDLE;
          end else begin
            slot_d  = slot_q + CW'(1);
            state_d = sfrt_pkg::ST_SP_RD;
          end
        end
      end
      default: state_d = sfrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sfrt_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      cnt_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_vld_q <= cnt_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    idx_q      <= idx_d;
    tgt_q      <= tgt_d;
    syn_q      <= syn_d;
    rng_q      <= rng_d;
    cnt_q      <= cnt_d;
    slot_q     <= slot_d;
    out_kind_q <= out_kind_d;
    out_acc_q  <= out_acc_d;
    out_src_q  <= out_src_d;
    out_tgt_q  <= out_tgt_d;
    out_syn_q  <= out_syn_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.result_kind    = out_kind_q;
  assign res_o.accepted       = out_acc_q;
  assign res_o.source_index   = out_src_q;
  assign res_o.target_neuron  = out_tgt_q;
  assign res_o.target_synapse = out_syn_q;
  assign res_o.last           = out_last_q;

`ifndef SYNTHESIS
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_kind_q == sfrt_pkg::KindAck)) |-> out_last_q)
    else $error("add acknowledgement without last");

  a_fwd_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_kind_q == sfrt_pkg::KindFwd)) |-> !out_acc_q)
    else $error("forwarded address marked accepted");

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == sfrt_pkg::ST_RD_CNT))
    else $error("accepted item did not start count lookup");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfrt_pkg::ST_SP_OUT) |-> (slot_q < cnt_q))
    else $error("spike replay beyond stored count");
`endif

endmodule

`default_nettype wire

@@ tb/spike_fanout_routing_table_core_test.sv @@
`timescale 1ns / 1ps

module spike_fanout_routing_table_core_test;

  localparam int NUM_NEURONS  = sfrt_pkg::NumNeuronsDef;
  localparam int FANOUT       = sfrt_pkg::FanoutDef;
  localparam int RANDOM_ITEMS = 155;
  localparam int HOT_SOURCES  = 6;
  localparam int MAX_WAIT     = 17;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 60;
  localparam int DRAIN_CYCLES = 2 * FANOUT + 32;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic       req_type;
    logic [7:0] source_neuron;
    logic [7:0] target_code;
    logic [7:0] target_synapse_in;
  } route_req_t;

  typedef struct packed {
    logic       result_kind;
    logic       accepted;
    logic [7:0] source_index;
    logic [7:0] target_neuron;
    logic [7:0] target_synapse;
    logic       last;
  } route_res_t;

  class routing_scoreboard;
    logic [$clog2(FANOUT+1)-1:0] fanout_len [NUM_NEURONS];
    logic [15:0]                 fanout_addr [NUM_NEURONS][FANOUT];
    route_res_t                  awaited[$];
    int unsigned                 mismatches;

    function new();
      foreach (fanout_len[i]) fanout_len[i] = '0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // Update the table copy and queue the beats this request should produce
    function void apply_request(route_req_t rq);
      route_res_t  want;
      logic [7:0]  idx;
      logic [7:0]  tgt;
      int unsigned i;
      if (rq.req_type == sfrt_pkg::ReqAdd) begin
        idx = rq.source_neuron - sfrt_pkg::CodeOffset;
        tgt = rq.target_code - sfrt_pkg::CodeOffset;
        want.accepted = 1'b0;
        if (idx < NUM_NEURONS) begin
          if (fanout_len[idx] < FANOUT) begin
            fanout_addr[idx][fanout_len[idx]] = {tgt, rq.target_synapse_in};
            fanout_len[idx] = fanout_len[idx] + 1'b1;
            want.accepted = 1'b1;
          end
        end
        want.result_kind    = sfrt_pkg::KindAck;
        want.source_index   = idx;
        want.target_neuron  = tgt;
        want.target_synapse = rq.target_synapse_in;
        want.last           = 1'b1;
        awaited.push_back(want);
      end else if (rq.source_neuron < NUM_NEURONS) begin
        idx = rq.source_neuron;
        for (i = 0; i < fanout_len[idx]; i++) begin
          want.result_kind    = sfrt_pkg::KindFwd;
          want.accepted       = 1'b0;
          want.source_index   = idx;
          want.target_neuron  = fanout_addr[idx][i][15:8];
          want.target_synapse = fanout_addr[idx][i][7:0];
          want.last           = (i + 1 == fanout_len[idx]);
          awaited.push_back(want);
        end
      end
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(route_res_t got);
      route_res_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.result_kind !== want.result_kind)
        report("result_kind", 8'(want.result_kind), 8'(got.result_kind));
      if (got.accepted !== want.accepted)
        report("accepted", 8'(want.accepted), 8'(got.accepted));
      if (got.source_index !== want.source_index)
        report("source_index", want.source_index, got.source_index);
      if (got.target_neuron !== want.target_neuron)
        report("target_neuron", want.target_neuron, got.target_neuron);
      if (got.target_synapse !== want.target_synapse)
        report("target_synapse", want.target_synapse, got.target_synapse);
      if (got.last !== want.last)
        report("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sfrt_req_if req_ch ();
  sfrt_res_if res_ch ();

  spike_fanout_routing_table_core #(
    .NUM_NEURONS(NUM_NEURONS),
    .FANOUT     (FANOUT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .res_o (res_ch)
  );

  routing_scoreboard table_sb = new();
  bit                sender_burst;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready)
        table_sb.apply_request({req_ch.req_type, req_ch.source_neuron,
                                req_ch.target_code, req_ch.target_synapse_in});
      if (res_ch.valid && res_ch.ready)
        table_sb.check_result({res_ch.result_kind, res_ch.accepted, res_ch.source_index,
                               res_ch.target_neuron, res_ch.target_synapse, res_ch.last});
    end
  end

  task automatic send_request(input logic kind, input logic [7:0] src,
                              input logic [7:0] tcode, input logic [7:0] syn);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid             <= 1'b1;
    req_ch.req_type          <= kind;
    req_ch.source_neuron     <= src;
    req_ch.target_code       <= tcode;
    req_ch.target_synapse_in <= syn;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Receiver: random back-pressure, bursts with none, and one long hold-off
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          held;
    bit          burst;
    taken = 0;
    held  = 1'b0;
    burst = 1'b0;
    res_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (taken % 24 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (!held && taken >= HOLD_AFTER) begin
        stall = LONG_HOLD;
        held  = 1'b1;
      end
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      taken++;
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("spike_fanout_routing_table_core_test: FAIL");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    logic [7:0]  hot;
    sender_burst = 1'b0;
    rst_ni                   <= 1'b0;
    req_ch.valid             <= 1'b0;
    req_ch.req_type          <= sfrt_pkg::ReqAdd;
    req_ch.source_neuron     <= '0;
    req_ch.target_code       <= '0;
    req_ch.target_synapse_in <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Edge codes: lowest and highest source, out-of-range sources, target wrap
    send_request(sfrt_pkg::ReqAdd, sfrt_pkg::CodeOffset, 8'd0, 8'd0);
    send_request(sfrt_pkg::ReqAdd, sfrt_pkg::CodeOffset + 8'(NUM_NEURONS - 1),
                 8'd255, 8'd255);
    send_request(sfrt_pkg::ReqAdd, sfrt_pkg::CodeOffset + 8'(NUM_NEURONS),
                 sfrt_pkg::CodeOffset, 8'hAA);
    send_request(sfrt_pkg::ReqAdd, sfrt_pkg::CodeOffset - 8'd1,
                 sfrt_pkg::CodeOffset - 8'd1, 8'h55);
    send_request(sfrt_pkg::ReqSpike, 8'(NUM_NEURONS - 1), 8'd0, 8'd0);
    send_request(sfrt_pkg::ReqSpike, 8'(NUM_NEURONS), 8'd0, 8'd0);
    send_request(sfrt_pkg::ReqSpike, 8'd255, 8'hFF, 8'hFF);
    send_request(sfrt_pkg::ReqSpike, 8'd5, 8'd0, 8'd0);
    // Fill source 0 and go one past full, then replay the whole list
    for (n = 0; n < FANOUT; n++)
      send_request(sfrt_pkg::ReqAdd, sfrt_pkg::CodeOffset, 8'($urandom()), 8'($urandom()));
    send_request(sfrt_pkg::ReqSpike, 8'd0, 8'($urandom()), 8'($urandom()));

    // Mostly traffic on a few sources so lists fill and replays run long
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      hot  = 8'($urandom_range(0, HOT_SOURCES - 1));
      if (pick < 55)
        send_request(sfrt_pkg::ReqAdd, hot + sfrt_pkg::CodeOffset, 8'($urandom()),
                     8'($urandom()));
      else if (pick < 80)
        send_request(sfrt_pkg::ReqSpike, hot, 8'($urandom()), 8'($urandom()));
      else if (pick < 90)
        send_request(sfrt_pkg::ReqAdd, 8'($urandom()), 8'($urandom()), 8'($urandom()));
      else
        send_request(sfrt_pkg::ReqSpike, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    end
    req_ch.valid <= 1'b0;

    // Let the monitor book the final beat before looking at the queue
    @(posedge clk_i);
    while (table_sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (table_sb.mismatches == 0)
      $display("spike_fanout_routing_table_core_test: PASS");
    else
      $display("spike_fanout_routing_table_core_test: FAIL");
    $finish;
  end

endmodule
